[sv/skt_pkg.sv]
// skt_pkg: shared types and constants for the sorted key table.
// No dependencies; imported by skt_ctrl, sorted_key_table_unit and the bench.
package skt_pkg;

    localparam int DEPTH    = 64;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int KEY_W    = 40;
    localparam int ENTRY_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  entry_count;
    } resp_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [KEY_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_cmd_t;

endpackage

[sv/skt_ram.sv]
// skt_ram: simple dual-port RAM, one write and one registered read port.
// No dependencies.
module skt_ram #(
    parameter int DATA_W = 40,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/skt_ctrl.sv]
// skt_ctrl: sequencer that walks the key memory for insert and delete.
// Depends on skt_pkg; drives skt_ram through a mem_cmd_t.
module skt_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    input  skt_pkg::req_t            req,
    output logic                     busy,
    output skt_pkg::mem_cmd_t        mem_cmd,
    input  logic [skt_pkg::KEY_W-1:0] rd_data,
    output logic                     res_valid,
    output skt_pkg::resp_t           res,
    input  logic                     res_ready
);
    import skt_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS      = 3'd1;
    localparam logic [2:0] S_INS_HEAD = 3'd2;
    localparam logic [2:0] S_DEL      = 3'd3;
    localparam logic [2:0] S_DONE     = 3'd4;

    logic [2:0]          state_reg,  state_next;
    logic [KEY_W-1:0]    key_reg,    key_next;
    logic [ADDR_W-1:0]   idx_reg,    idx_next;
    logic                found_reg,  found_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                is_last;
    logic                is_eq;

    assign is_last = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));
    assign is_eq   = (rd_data == key_reg);

    always_comb
    begin
        state_next  = state_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        count_next  = count_reg;
        status_next = status_reg;
        mem_cmd     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    key_next   = req.key;
                    found_next = 1'b0;
                    if (req.func == FUNC_INSERT)
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = S_INS_HEAD;
                        end
                        else
                        begin
                            mem_cmd.re    = 1'b1;
                            mem_cmd.raddr = ADDR_W'(count_reg - CNT_W'(1));
                            idx_next      = ADDR_W'(count_reg - CNT_W'(1));
                            state_next    = S_INS;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_NOT_FOUND;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            mem_cmd.re    = 1'b1;
                            mem_cmd.raddr = '0;
                            idx_next      = '0;
                            state_next    = S_DEL;
                        end
                    end
                end
            end
            // top-down: shift keys not smaller than the new key up by one
            S_INS:
            begin
                mem_cmd.we    = 1'b1;
                mem_cmd.waddr = idx_reg + ADDR_W'(1);
                if (rd_data >= key_reg)
                begin
                    mem_cmd.wdata = rd_data;
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS_HEAD;
                    end
                    else
                    begin
                        mem_cmd.re    = 1'b1;
                        mem_cmd.raddr = idx_reg - ADDR_W'(1);
                        idx_next      = idx_reg - ADDR_W'(1);
                    end
                end
                else
                begin
                    mem_cmd.wdata = key_reg;
                    count_next    = count_reg + CNT_W'(1);
                    status_next   = ST_INSERTED;
                    state_next    = S_DONE;
                end
            end
            S_INS_HEAD:
            begin
                mem_cmd.we    = 1'b1;
                mem_cmd.waddr = '0;
                mem_cmd.wdata = key_reg;
                count_next    = count_reg + CNT_W'(1);
                status_next   = ST_INSERTED;
                state_next    = S_DONE;
            end
            // bottom-up: find first match, then move later keys down by one
            S_DEL:
            begin
                if (found_reg)
                begin
                    mem_cmd.we    = 1'b1;
                    mem_cmd.waddr = idx_reg - ADDR_W'(1);
                    mem_cmd.wdata = rd_data;
                end
                found_next = found_reg | is_eq;
                if (is_last)
                begin
                    if (found_reg | is_eq)
                    begin
                        count_next  = count_reg - CNT_W'(1);
                        status_next = ST_DELETED;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    mem_cmd.re    = 1'b1;
                    mem_cmd.raddr = idx_reg + ADDR_W'(1);
                    idx_next      = idx_reg + ADDR_W'(1);
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign busy            = (state_reg != S_IDLE);
    assign res_valid       = (state_reg == S_DONE);
    assign res.status      = status_reg;
    assign res.entry_count = ENTRY_W'(count_reg);

endmodule

[sv/sorted_key_table_unit.sv]
// sorted_key_table_unit: top level of the sorted key table.
// Depends on skt_pkg, skt_ram and skt_ctrl.
//
// Keeps up to DEPTH (64) 40-bit keys in ascending order in one RAM.
// Request channel (req_valid / req_stall / req): func 0 inserts the key
// ahead of any equal keys, func 1 deletes the first equal key.
// Response channel (resp_valid / resp_stall / resp): one response per
// request with status (inserted, full, deleted, not found) and the count.
// One request is in flight at a time; req_stall is high while it is walked.
// Insert walks down from the top of the table to the insert position, delete
// walks up from the bottom to the last entry; the walk is bounded by the single
// RAM read port, one entry per cycle. Full insert or empty delete skip the walk.
// A finished response sits in an output register; the next request is
// taken while it waits. If resp_stall holds and another response is ready,
// the sequencer waits and req_stall stays high.
// Reset empties the table at once; no clearing pass is needed.
module sorted_key_table_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  skt_pkg::req_t  req,
    output logic           resp_valid,
    input  logic           resp_stall,
    output skt_pkg::resp_t resp
);
    import skt_pkg::*;

    mem_cmd_t         mem_cmd;
    logic [KEY_W-1:0] rd_data;
    logic             busy;
    logic             res_valid;
    resp_t            res;
    logic             res_ready;
    logic             push;
    logic             out_valid_reg, out_valid_next;
    resp_t            out_data_reg;

    skt_ram #(
        .DATA_W (KEY_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_cmd.we),
        .waddr (mem_cmd.waddr),
        .wdata (mem_cmd.wdata),
        .re    (mem_cmd.re),
        .raddr (mem_cmd.raddr),
        .rdata (rd_data)
    );

    skt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .busy      (busy),
        .mem_cmd   (mem_cmd),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    assign req_stall = busy;
    assign res_ready = !out_valid_reg || !resp_stall;
    assign push      = res_valid && res_ready;

    always_comb
    begin
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (!resp_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_data_reg <= res;
        end
    end

    assign resp_valid = out_valid_reg;
    assign resp       = out_data_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while another is in flight");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_cmd.we && mem_cmd.re) |-> (mem_cmd.waddr != mem_cmd.raddr))
        else $error("RAM read and write hit the same entry");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid |-> (resp.entry_count <= ENTRY_W'(DEPTH)))
        else $error("entry count above table depth");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (resp_valid && resp.status == ST_FULL) |-> (resp.entry_count == ENTRY_W'(DEPTH)))
        else $error("full status with table not full");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: self-checking bench for sorted_key_table_unit, a table of keys kept in sort order.
// Keeps a shadow copy of the table to predict each response. Uses skt_pkg and the RTL only.
module tb_top;
    import skt_pkg::*;

    localparam int LONG_HOLD_CYCLES = 300;

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  req_valid  = 1'b0;
    logic  req_stall;
    req_t  req        = '0;
    logic  resp_valid;
    logic  resp_stall = 1'b0;
    resp_t resp;

    sorted_key_table_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .resp_valid (resp_valid),
        .resp_stall (resp_stall),
        .resp       (resp)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout at %0t", $time);
        $display("Test completed with failures");
        $finish;
    end

    req_t             queued_reqs[$];
    resp_t            due_resps[$];
    logic [KEY_W-1:0] issued_keys[$];
    logic [KEY_W-1:0] shadow_keys[DEPTH];
    int               shadow_count = 0;

    bit    send_idle_on = 1'b0;
    bit    recv_idle_on = 1'b0;
    bit    offering;
    int    send_gap = 0;
    int    recv_gap = 0;
    int    hold_left = 0;
    int    long_hold_requests = 0;
    int    long_holds_done = 0;
    int    errors = 0;
    int    reqs_taken = 0;
    int    status_seen[4] = '{0, 0, 0, 0};
    resp_t due_front;

    // Shadow table update; returns the response the block owes for this request.
    function automatic resp_t apply_to_shadow(req_t r);
        resp_t o;
        int    pos;
        o = '0;
        pos = 0;
        if (r.func == FUNC_INSERT)
        begin
            if (shadow_count >= DEPTH)
                o.status = ST_FULL;
            else
            begin
                while (pos < shadow_count && shadow_keys[pos] < r.key)
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                    shadow_keys[i] = shadow_keys[i - 1];
                shadow_keys[pos] = r.key;
                shadow_count++;
                o.status = ST_INSERTED;
            end
        end
        else
        begin
            while (pos < shadow_count && shadow_keys[pos] != r.key)
                pos++;
            if (pos < shadow_count)
            begin
                for (int i = pos; i + 1 < shadow_count; i++)
                    shadow_keys[i] = shadow_keys[i + 1];
                shadow_count--;
                o.status = ST_DELETED;
            end
            else
                o.status = ST_NOT_FOUND;
        end
        o.entry_count = ENTRY_W'(shadow_count);
        return o;
    endfunction

    // Mostly recently inserted keys for deletes, so most deletes hit.
    function automatic logic [KEY_W-1:0] pick_key(bit for_delete);
        int roll;
        roll = int'($urandom_range(0, 99));
        if (issued_keys.size() > 0 && roll < (for_delete ? 70 : 30))
            return issued_keys[$urandom_range(0, issued_keys.size() - 1)];
        if (roll < 85)
            return {8'($urandom), 32'($urandom)};
        if (roll < 97)
            return KEY_W'($urandom_range(0, 7));
        return '1;
    endfunction

    task automatic queue_req(logic f, logic [KEY_W-1:0] k);
        req_t r;
        r.func = f;
        r.key = k;
        queued_reqs.push_back(r);
        if (f == FUNC_INSERT)
        begin
            issued_keys.push_back(k);
            if (issued_keys.size() > 96)
                issued_keys.delete(0);
        end
    endtask

    task automatic queue_phase(int n, int insert_pct);
        logic f;
        for (int i = 0; i < n; i++)
        begin
            f = (int'($urandom_range(0, 99)) < insert_pct) ? FUNC_INSERT : FUNC_DELETE;
            queue_req(f, pick_key(f == FUNC_DELETE));
        end
    endtask

    // Sampled on the falling edge so the driver's updates have settled.
    task automatic wait_idle();
        while (queued_reqs.size() != 0 || req_valid || due_resps.size() != 0)
            @(negedge clk);
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            send_gap = 0;
        end
        else
        begin
            offering = req_valid;
            if (req_valid && !req_stall)
            begin
                due_resps.push_back(apply_to_shadow(req));
                offering = 1'b0;
                reqs_taken++;
                if (send_idle_on && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 15);
            end
            if (!offering)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (queued_reqs.size() > 0)
                begin
                    req <= queued_reqs.pop_front();
                    offering = 1'b1;
                end
            end
            req_valid <= offering;
        end
    end

    // Response stall: random bursts plus a long hold when the test asks for one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_stall <= 1'b0;
            recv_gap = 0;
            hold_left = 0;
        end
        else
        begin
            if (long_holds_done < long_hold_requests)
            begin
                hold_left = LONG_HOLD_CYCLES;
                long_holds_done++;
            end
            if (hold_left > 0)
                hold_left--;
            else if (recv_gap > 0)
                recv_gap--;
            else if (recv_idle_on && $urandom_range(0, 9) == 0)
                recv_gap = $urandom_range(1, 15);
            resp_stall <= (hold_left > 0) || (recv_gap > 0);
        end
    end

    // Response monitor
    always @(posedge clk)
    begin
        if (rst_n && resp_valid && !resp_stall)
        begin
            if (due_resps.size() == 0)
            begin
                $display("%0t: response with none due: status %0d count %0d",
                         $time, resp.status, resp.entry_count);
                errors++;
            end
            else
            begin
                due_front = due_resps.pop_front();
                status_seen[due_front.status]++;
                if (resp.status !== due_front.status)
                begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, due_front.status, resp.status);
                    errors++;
                end
                if (resp.entry_count !== due_front.entry_count)
                begin
                    $display("%0t: entry_count mismatch: expected %0d actual %0d",
                             $time, due_front.entry_count, resp.entry_count);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        // directed: empty table, extreme keys, duplicates, key zero
        queue_req(FUNC_DELETE, KEY_W'(5));
        queue_req(FUNC_INSERT, '1);
        queue_req(FUNC_INSERT, '0);
        queue_req(FUNC_INSERT, {20{2'b01}});
        queue_req(FUNC_INSERT, {20{2'b10}});
        queue_req(FUNC_INSERT, 40'h12_3456_789A);
        queue_req(FUNC_INSERT, 40'h12_3456_789A);
        queue_req(FUNC_INSERT, '0);
        queue_req(FUNC_DELETE, '0);
        queue_req(FUNC_DELETE, '0);
        queue_req(FUNC_DELETE, '0);
        queue_req(FUNC_DELETE, 40'h12_3456_789A);
        queue_req(FUNC_DELETE, 40'h12_3456_789B);
        queue_req(FUNC_DELETE, 40'h12_3456_789A);
        queue_req(FUNC_DELETE, '1);
        queue_req(FUNC_DELETE, {20{2'b01}});
        queue_req(FUNC_DELETE, {20{2'b10}});
        queue_req(FUNC_DELETE, '1);
        wait_idle();

        // long response hold while requests keep coming
        long_hold_requests++;
        queue_phase(40, 80);
        wait_idle();

        for (int ph = 0; ph < 18; ph++)
        begin
            send_idle_on = (ph < 15) && ($urandom_range(0, 3) != 0);
            recv_idle_on = (ph < 15) && ($urandom_range(0, 3) != 0);
            case (ph % 4)
                0: queue_phase(110, 90);
                1: queue_phase(110, 55);
                2: queue_phase(110, 10);
                default: queue_phase(110, 50);
            endcase
            if ($urandom_range(0, 2) == 0)
                wait_idle();
        end
        wait_idle();
        repeat (DEPTH + 10) @(posedge clk);

        if (due_resps.size() != 0)
        begin
            $display("%0t: %0d responses never arrived", $time, due_resps.size());
            errors++;
        end
        $display("Sent %0d requests: %0d inserted, %0d refused full, %0d deleted, %0d not found.",
                 reqs_taken, status_seen[ST_INSERTED], status_seen[ST_FULL],
                 status_seen[ST_DELETED], status_seen[ST_NOT_FOUND]);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sorted_key_table_unit.f]
sv/skt_pkg.sv
sv/skt_ram.sv
sv/skt_ctrl.sv
sv/sorted_key_table_unit.sv
bench/tb_top.sv
